// ----- sv/qoi_pixel_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// QOI pixel encoder assertion macros
// Shorthand for the concurrent checks on the encoder ports.
// ----------------------------------------------------------------------------
`ifndef QOI_PIXEL_ENCODER_MACROS_SVH
`define QOI_PIXEL_ENCODER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define QOIENC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define QOIENC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/qoienc_pkg.sv -----
// ----------------------------------------------------------------------------
// QOI encoder package
// Opcodes, colour index geometry, output burst types and the index hash.
// ----------------------------------------------------------------------------
`default_nettype none

package qoienc_pkg;

   // colour index geometry
   localparam int unsigned INDEX_ENTRIES = 64;
   localparam int unsigned HASH_W        = $clog2(INDEX_ENTRIES);

   // chunk opcodes
   localparam logic [7:0] OP_INDEX = 8'h00;
   localparam logic [7:0] OP_RUN   = 8'hC0;
   localparam logic [7:0] OP_RGB   = 8'hFE;
   localparam logic [7:0] OP_RGBA  = 8'hFF;

   // end marker: seven zero bytes then one
   localparam int unsigned  END_ZEROS = 7;
   localparam logic [7:0]   END_TAIL  = 8'h01;

   // channel count codes
   localparam logic [2:0] CH_RGB   = 3'd3;
   localparam logic [2:0] CH_RESET = 3'd4;

   // previous pixel after reset: black, opaque
   localparam logic [31:0] PIXEL_RESET = 32'h0000_00FF;

   // most bytes one pixel can cause: run flush, RGBA literal, end marker
   localparam int unsigned BURST_BYTES = 14;

   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  count_type;
   typedef logic [31:0] pixel_type;
   typedef logic [HASH_W-1:0] hash_type;

   typedef struct packed {
      byte_type [BURST_BYTES-1:0] bytes;
      count_type                  count;
   } burst_type;

   typedef struct packed {
      logic      valid;
      burst_type burst;
   } load_type;

   // (3r + 5g + 7b + 11a) mod 64; only the low six bits of each term matter
   function automatic hash_type pixel_hash(input pixel_type px);
      hash_type r6;
      hash_type g6;
      hash_type b6;
      hash_type a6;
      r6 = px[24 +: HASH_W];
      g6 = px[16 +: HASH_W];
      b6 = px[8 +: HASH_W];
      a6 = px[0 +: HASH_W];
      return hash_type'(r6 * hash_type'(3) + g6 * hash_type'(5)
                        + b6 * hash_type'(7) + a6 * hash_type'(11));
   endfunction

endpackage

`default_nettype wire

// ----- sv/qoienc_ifs.sv -----
// ----------------------------------------------------------------------------
// QOI encoder channel interfaces
// Pixel input, encoded byte output and channel count write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface qoienc_pixel_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last_pixel;

   modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

interface qoienc_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

interface qoienc_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] channel_count;

   modport source (output valid, channel_count, input ready);
   modport sink   (input valid, channel_count, output ready);
endinterface

`default_nettype wire

// ----- sv/qoienc_serialiser.sv -----
// ----------------------------------------------------------------------------
// QOI encoder byte serialiser
// Holds one pixel's burst of chunk bytes and hands them out one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module qoienc_serialiser
   import qoienc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire load_type      load,
   output logic               can_load,
   qoienc_byte_if.source      rsp_ch
);

   byte_type [BURST_BYTES-1:0] bytes_ff;
   byte_type [BURST_BYTES-1:0] bytes_in;
   count_type                  count_ff;
   count_type                  count_in;
   logic                       rsp_fire;

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // free now, or the last byte leaves this cycle
   assign can_load = (count_ff == '0) || ((count_ff == count_type'(1)) && rsp_ch.ready);

   // load a new burst or shift out the head byte
   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (load.valid && can_load) begin
         bytes_in = load.burst.bytes;
         count_in = load.burst.count;
      end else if (rsp_fire) begin
         for (int i = 0; i < BURST_BYTES - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         bytes_in[BURST_BYTES-1] = '0;
         count_in = count_ff - count_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.out_byte  = bytes_ff[0];
   assign rsp_ch.last_byte = (count_ff == count_type'(1));

endmodule

`default_nettype wire

// ----- sv/qoi_pixel_encoder.sv -----
// ----------------------------------------------------------------------------
// QOI pixel encoder
// One RGBA pixel per input transaction in, QOI chunk bytes out (no header).
// ----------------------------------------------------------------------------
// Pixels are accepted back to back while the serialiser can take a new burst.
// An accepted pixel reads the 64-entry colour index on acceptance, is encoded
// from the registered input stage, and its bytes leave the serialiser one at a
// time. The serialiser's single byte lane sets the rate: a run that carries
// on emits no bytes, an index hit or a run flush alone one, an RGB literal
// four and an RGBA literal five, one more when an open run is flushed first,
// up to fourteen for a last pixel with run flush, RGBA literal and end marker.
// The colour index is cleared by per-entry valid bits, so reset and image end
// need no clearing pass. channel_count must be written only while the block
// idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_pixel_encoder
   import qoienc_pkg::*;
#(
   parameter int unsigned MAX_RUN = 62
) (
   input  wire logic       clock,
   input  wire logic       reset,
   qoienc_pixel_if.sink    req_ch,
   qoienc_byte_if.source   rsp_ch,
   qoienc_csr_if.sink      csr_ch
);

   localparam logic [5:0] RUN_LIMIT = 6'(MAX_RUN);

   // configuration
   logic [2:0] chan_ff;
   logic       rgb_mode;

   // input stage
   logic      req_fire;
   pixel_type px_in;
   hash_type  hash_in;
   logic      a_valid_ff;
   logic      a_valid_in;
   pixel_type a_px_ff;
   hash_type  a_hash_ff;
   logic      a_last_ff;
   logic      a_move;

   // colour index memory and its bookkeeping
   pixel_type                 index_mem [INDEX_ENTRIES];
   pixel_type                 rd_data_ff;
   logic [INDEX_ENTRIES-1:0]  idx_valid_ff;
   logic [INDEX_ENTRIES-1:0]  idx_valid_in;
   hash_type                  lw_addr_ff;
   pixel_type                 lw_data_ff;

   // encoder state
   pixel_type prev_ff;
   pixel_type prev_in;
   logic [5:0] run_ff;
   logic [5:0] run_in;

   // encode decision
   pixel_type entry;
   logic      repeat_px;
   logic      hit;
   logic      mem_we;
   logic [5:0] run_inc;
   load_type  load;
   logic      can_load;

   assign rgb_mode = (chan_ff == CH_RGB);

   // configuration register, always ready
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= CH_RESET;
      end else if (csr_ch.valid) begin
         chan_ff <= csr_ch.channel_count;
      end
   end

   // input acceptance; alpha forced opaque in RGB mode
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign px_in     = {req_ch.red, req_ch.green, req_ch.blue,
                       rgb_mode ? 8'hFF : req_ch.alpha};
   assign hash_in   = pixel_hash(px_in);
   assign a_move    = a_valid_ff && can_load;
   assign req_ch.ready = !a_valid_ff || can_load;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_px_ff   <= px_in;
         a_hash_ff <= hash_in;
         a_last_ff <= req_ch.last_pixel;
      end
   end

   // colour index: read on acceptance, write back on a miss
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= index_mem[hash_in];
      end
      if (mem_we) begin
         index_mem[a_hash_ff] <= a_px_ff;
      end
   end

   // last write kept for forwarding to a read issued on the same edge
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lw_addr_ff <= a_hash_ff;
         lw_data_ff <= a_px_ff;
      end
   end

   // entry as seen now: cleared entries read zero
   always_comb begin
      if (!idx_valid_ff[a_hash_ff]) begin
         entry = '0;
      end else if (lw_addr_ff == a_hash_ff) begin
         entry = lw_data_ff;
      end else begin
         entry = rd_data_ff;
      end
   end

   assign repeat_px = (a_px_ff == prev_ff);
   assign hit       = (entry == a_px_ff);
   assign run_inc   = run_ff + 6'd1;
   assign mem_we    = a_move && !repeat_px && !hit;

   // build the pixel's byte burst
   always_comb begin
      count_type pos;
      pos = '0;
      load.valid = a_move;
      load.burst.bytes = '0;
      if (repeat_px) begin
         if ((run_inc >= RUN_LIMIT) || a_last_ff) begin
            load.burst.bytes[pos] = OP_RUN | {2'b00, run_inc - 6'd1};
            pos = pos + count_type'(1);
         end
      end else begin
         if (run_ff != '0) begin
            load.burst.bytes[pos] = OP_RUN | {2'b00, run_ff - 6'd1};
            pos = pos + count_type'(1);
         end
         if (hit) begin
            load.burst.bytes[pos] = OP_INDEX | {2'b00, a_hash_ff};
            pos = pos + count_type'(1);
         end else begin
            load.burst.bytes[pos] = rgb_mode ? OP_RGB : OP_RGBA;
            load.burst.bytes[pos + count_type'(1)] = a_px_ff[31:24];
            load.burst.bytes[pos + count_type'(2)] = a_px_ff[23:16];
            load.burst.bytes[pos + count_type'(3)] = a_px_ff[15:8];
            pos = pos + count_type'(4);
            if (!rgb_mode) begin
               load.burst.bytes[pos] = a_px_ff[7:0];
               pos = pos + count_type'(1);
            end
         end
      end
      // end marker: zeros already in place, then the closing one
      if (a_last_ff) begin
         pos = pos + count_type'(END_ZEROS);
         load.burst.bytes[pos] = END_TAIL;
         pos = pos + count_type'(1);
      end
      load.burst.count = pos;
   end

   // encoder state update
   always_comb begin
      prev_in      = prev_ff;
      run_in       = run_ff;
      idx_valid_in = idx_valid_ff;
      if (a_move) begin
         if (repeat_px) begin
            run_in = ((run_inc >= RUN_LIMIT) || a_last_ff) ? 6'd0 : run_inc;
         end else begin
            run_in  = '0;
            prev_in = a_px_ff;
            if (!hit) begin
               idx_valid_in[a_hash_ff] = 1'b1;
            end
         end
         // image end: back to the reset state
         if (a_last_ff) begin
            prev_in      = PIXEL_RESET;
            run_in       = '0;
            idx_valid_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= PIXEL_RESET;
         run_ff       <= '0;
         idx_valid_ff <= '0;
      end else begin
         prev_ff      <= prev_in;
         run_ff       <= run_in;
         idx_valid_ff <= idx_valid_in;
      end
   end

   // byte output
   qoienc_serialiser u_serialiser (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sv/qoienc_checker.sv -----
// ----------------------------------------------------------------------------
// QOI encoder port checker
// Watches the result channel of the encoder; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "qoi_pixel_encoder_macros.svh"

module qoienc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last_byte
);

   // a stalled byte transaction keeps its payload
   `QOIENC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte), "rsp stalled payload changed")

   // reset empties the serialiser
   `QOIENC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

   // bytes of one pixel follow without a gap
   `QOIENC_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_valid && rsp_ready && !rsp_last_byte, rsp_valid, "gap inside a pixel's byte burst")

endmodule

bind qoi_pixel_encoder qoienc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_last_byte (rsp_ch.last_byte)
);

`default_nettype wire
